// File: hdl/sldda_pkg.sv
// Shared constants, command type and widths for the 3D stroke line generator
`timescale 1ns / 1ps
`default_nettype none

package sldda_pkg;

  // coordinate and fixed-point widths
  localparam int COORD_W   = 6;
  localparam int FRAC_W    = 8;
  localparam int OUT_W     = COORD_W + FRAC_W;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int LEN_W     = COORD_W;
  localparam int MAG_W     = COORD_W + FRAC_W;
  localparam int NUM_AXES  = 3;

  // command queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // serial divider step counter
  localparam int DIV_CNT_W = $clog2(MAG_W);

  typedef enum logic {
    CMD_POINT,
    CMD_SEGMENT
  } cmd_kind_t;

  // one unit of work for the back end; lane 0 is x, 1 is y, 2 is z
  typedef struct packed {
    cmd_kind_t                          kind;
    logic [NUM_AXES-1:0]                neg;
    logic [NUM_AXES-1:0][COORD_W-1:0]   mag;
    logic [NUM_AXES-1:0][COORD_W-1:0]   base;
    logic [LEN_W-1:0]                   len;
  } seg_cmd_t;

endpackage

`default_nettype wire

// File: hdl/sldda_front.sv
// Front end: accepts stroke points, keeps the last point and classifies segments
`timescale 1ns / 1ps
`default_nettype none

module sldda_front
  import sldda_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic signed [COORD_W-1:0] in_point_z,
  input  wire logic                      in_stroke_start,
  input  wire logic                      q_full,
  output logic                           q_push,
  output seg_cmd_t                       q_cmd
);

  logic [COORD_W-1:0]        new_pt [NUM_AXES];
  logic [COORD_W-1:0]        prev_r [NUM_AXES];
  logic                      have_prev_r;
  logic signed [DELTA_W-1:0] delta [NUM_AXES];
  logic [DELTA_W-1:0]        abs_full [NUM_AXES];
  logic [COORD_W-1:0]        mag [NUM_AXES];
  logic [LEN_W-1:0]          len;
  logic                      accept;
  logic                      is_point;

  assign new_pt[0] = in_point_x;
  assign new_pt[1] = in_point_y;
  assign new_pt[2] = in_point_z;

  assign accept   = push && !q_full;
  assign is_point = in_stroke_start || !have_prev_r;

  // per-axis delta and magnitude
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      delta[k]    = DELTA_W'($signed(new_pt[k])) - DELTA_W'($signed(prev_r[k]));
      abs_full[k] = delta[k][DELTA_W-1] ? DELTA_W'(-delta[k]) : DELTA_W'(delta[k]);
      mag[k]      = abs_full[k][COORD_W-1:0];
    end
  end

  // major axis: z if strictly largest, else y if above x, else x
  always_comb begin
    priority if (mag[2] > mag[0] && mag[2] > mag[1]) begin
      len = mag[2];
    end else if (mag[1] > mag[0]) begin
      len = mag[1];
    end else begin
      len = mag[0];
    end
  end

  // command to the back end
  always_comb begin
    q_cmd.kind = is_point ? CMD_POINT : CMD_SEGMENT;
    q_cmd.len  = len;
    for (int k = 0; k < NUM_AXES; k++) begin
      q_cmd.neg[k]  = delta[k][DELTA_W-1];
      q_cmd.mag[k]  = mag[k];
      q_cmd.base[k] = is_point ? new_pt[k] : prev_r[k];
    end
  end

  // zero-length segments are dropped
  assign q_push = accept && (is_point || (len != '0));

  // kept point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
        prev_r[k] <= '0;
      end
    end else if (accept) begin
      have_prev_r <= 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
        prev_r[k] <= new_pt[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/sldda_queue.sv
// Short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module sldda_queue
  import sldda_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire seg_cmd_t wr_cmd,
  output logic          full,
  input  wire logic     rd_en,
  output seg_cmd_t      rd_cmd,
  output logic          empty
);

  seg_cmd_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_wr;
  logic              do_rd;

  assign full   = (count_r == QCNT_W'(QDEPTH));
  assign empty  = (count_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hdl/sldda_back.sv
// Back end: serial divide for the per-point step, then one point per cycle while the output is free
`timescale 1ns / 1ps
`default_nettype none

module sldda_back
  import sldda_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire seg_cmd_t          q_cmd,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic signed [OUT_W-1:0] out_x,
  output logic signed [OUT_W-1:0] out_y,
  output logic signed [OUT_W-1:0] out_z,
  output logic                   out_last_point
);

  localparam int EXT_W = OUT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STEP
  } state_t;

  state_t               state_r, state_nxt;
  logic [COORD_W-1:0]   base_r   [NUM_AXES];
  logic [COORD_W-1:0]   base_nxt [NUM_AXES];
  logic                 neg_r    [NUM_AXES];
  logic                 neg_nxt  [NUM_AXES];
  // dividend, then quotient once the divide is done
  logic [MAG_W-1:0]     num_r    [NUM_AXES];
  logic [MAG_W-1:0]     num_nxt  [NUM_AXES];
  logic [LEN_W-1:0]     rem_r    [NUM_AXES];
  logic [LEN_W-1:0]     rem_nxt  [NUM_AXES];
  logic [MAG_W-1:0]     accq_r   [NUM_AXES];
  logic [MAG_W-1:0]     accq_nxt [NUM_AXES];
  logic [LEN_W-1:0]     accr_r   [NUM_AXES];
  logic [LEN_W-1:0]     accr_nxt [NUM_AXES];
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0]     step_r, step_nxt;
  logic [OUT_W-1:0]     coord_r   [NUM_AXES];
  logic [OUT_W-1:0]     coord_nxt [NUM_AXES];
  logic                 last_r, last_nxt;
  logic                 valid_r, valid_nxt;

  // datapath intermediates
  logic [LEN_W:0]       trial     [NUM_AXES];
  logic                 ge        [NUM_AXES];
  logic [LEN_W:0]       rsum      [NUM_AXES];
  logic                 wrap      [NUM_AXES];
  logic [MAG_W-1:0]     accq_new  [NUM_AXES];
  logic signed [EXT_W-1:0] offs   [NUM_AXES];
  logic signed [EXT_W-1:0] base_ext [NUM_AXES];
  logic signed [EXT_W-1:0] coord_full [NUM_AXES];
  logic                 out_can;
  logic                 seg_last;

  assign out_can  = !valid_r || pop;
  assign seg_last = (step_r == len_r - LEN_W'(1));

  assign empty          = !valid_r;
  assign out_x          = coord_r[0];
  assign out_y          = coord_r[1];
  assign out_z          = coord_r[2];
  assign out_last_point = last_r;

  // restoring divide step and accumulator step, per lane
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      trial[k]    = {rem_r[k], num_r[k][MAG_W-1]};
      ge[k]       = (trial[k] >= {1'b0, len_r});
      rsum[k]     = {1'b0, accr_r[k]} + {1'b0, rem_r[k]};
      wrap[k]     = (rsum[k] >= {1'b0, len_r});
      accq_new[k] = accq_r[k] + num_r[k] + MAG_W'(wrap[k]);
      offs[k]     = neg_r[k] ? -$signed(EXT_W'(accq_new[k])) : $signed(EXT_W'(accq_new[k]));
      base_ext[k] = EXT_W'($signed(base_r[k])) <<< FRAC_W;
      coord_full[k] = base_ext[k] + offs[k];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !pop;
    q_pop     = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      base_nxt[k]  = base_r[k];
      neg_nxt[k]   = neg_r[k];
      num_nxt[k]   = num_r[k];
      rem_nxt[k]   = rem_r[k];
      accq_nxt[k]  = accq_r[k];
      accr_nxt[k]  = accr_r[k];
      coord_nxt[k] = coord_r[k];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == CMD_POINT) begin
            // stroke start: the point itself with a zero fraction
            if (out_can) begin
              q_pop     = 1'b1;
              valid_nxt = 1'b1;
              last_nxt  = 1'b1;
              for (int k = 0; k < NUM_AXES; k++) begin
                coord_nxt[k] = OUT_W'($signed(q_cmd.base[k])) <<< FRAC_W;
              end
            end
          end else begin
            q_pop     = 1'b1;
            len_nxt   = q_cmd.len;
            cnt_nxt   = '0;
            state_nxt = ST_DIVIDE;
            for (int k = 0; k < NUM_AXES; k++) begin
              base_nxt[k] = q_cmd.base[k];
              neg_nxt[k]  = q_cmd.neg[k];
              num_nxt[k]  = MAG_W'(q_cmd.mag[k]) << FRAC_W;
              rem_nxt[k]  = '0;
            end
          end
        end
      end
      ST_DIVIDE: begin
        // one quotient bit per cycle on all three lanes
        for (int k = 0; k < NUM_AXES; k++) begin
          num_nxt[k] = {num_r[k][MAG_W-2:0], ge[k]};
          rem_nxt[k] = ge[k] ? LEN_W'(trial[k] - {1'b0, len_r}) : trial[k][LEN_W-1:0];
        end
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(MAG_W - 1)) begin
          state_nxt = ST_STEP;
          step_nxt  = '0;
          for (int k = 0; k < NUM_AXES; k++) begin
            accq_nxt[k] = '0;
            accr_nxt[k] = '0;
          end
        end
      end
      ST_STEP: begin
        // add quotient and remainder, carry when remainder reaches length
        if (out_can) begin
          valid_nxt = 1'b1;
          last_nxt  = seg_last;
          step_nxt  = step_r + LEN_W'(1);
          for (int k = 0; k < NUM_AXES; k++) begin
            accq_nxt[k]  = accq_new[k];
            accr_nxt[k]  = wrap[k] ? LEN_W'(rsum[k] - {1'b0, len_r}) : rsum[k][LEN_W-1:0];
            coord_nxt[k] = coord_full[k][OUT_W-1:0];
          end
          if (seg_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    len_r  <= len_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
    last_r <= last_nxt;
    for (int k = 0; k < NUM_AXES; k++) begin
      base_r[k]  <= base_nxt[k];
      neg_r[k]   <= neg_nxt[k];
      num_r[k]   <= num_nxt[k];
      rem_r[k]   <= rem_nxt[k];
      accq_r[k]  <= accq_nxt[k];
      accr_r[k]  <= accr_nxt[k];
      coord_r[k] <= coord_nxt[k];
    end
  end

endmodule

`default_nettype wire

// File: hdl/stroke_line_dda_3d.sv
// Top level of the 3D stroke line generator: front end, command queue, back end
//
//   channel  ports                                       handshake
//   input    in_point_x/y/z, in_stroke_start             push, full
//   result   out_x/y/z, out_last_point                   empty, pop
//
// A stroke-start point (or the first point after reset) goes straight from the
// queue to the output. A segment of major length L is loaded, then serially
// divided (one quotient bit per cycle, COORD_W+FRAC_W steps), then gives L points,
// one point per cycle while the output is free. Zero-length segments cost nothing.
// Reset is synchronous; there is no clearing pass.
// A queue of two commands lets points be taken while the back end works or
// while pop is held low; full rises only when both entries are waiting.
`timescale 1ns / 1ps
`default_nettype none

module stroke_line_dda_3d
  import sldda_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [COORD_W-1:0] in_point_x,
  input  wire logic signed [COORD_W-1:0] in_point_y,
  input  wire logic signed [COORD_W-1:0] in_point_z,
  input  wire logic                      in_stroke_start,
  output logic                           empty,
  input  wire logic                      pop,
  output logic signed [OUT_W-1:0]        out_x,
  output logic signed [OUT_W-1:0]        out_y,
  output logic signed [OUT_W-1:0]        out_z,
  output logic                           out_last_point
);

  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  seg_cmd_t q_wr_cmd;
  seg_cmd_t q_rd_cmd;

  // classify incoming points
  sldda_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_stroke_start (in_stroke_start),
    .q_full          (full),
    .q_push          (q_push),
    .q_cmd           (q_wr_cmd)
  );

  // command queue
  sldda_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (full),
    .rd_en  (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  // point generation
  sldda_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_cmd          (q_rd_cmd),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_last_point (out_last_point)
  );

endmodule

`default_nettype wire

// File: hdl/sldda_checker.sv
// Port-level checks for the 3D stroke line generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module sldda_checker
  import sldda_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      push,
  input wire logic                      full,
  input wire logic                      empty,
  input wire logic                      pop,
  input wire logic signed [OUT_W-1:0]   out_x,
  input wire logic signed [OUT_W-1:0]   out_y,
  input wire logic signed [OUT_W-1:0]   out_z,
  input wire logic                      out_last_point
);

  // reset leaves no result waiting and room in the queue
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("results or full flag present after reset");

  // the queue fills only through a push
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

  // a result leaves only through a transfer
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(empty) |-> $past(pop))
    else $error("result dropped without a pop");

  // a waiting result holds until transferred
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)
                          && $stable(out_last_point)))
    else $error("waiting result changed");

endmodule

bind stroke_line_dda_3d sldda_checker u_sldda_checker (.*);

`default_nettype wire

// File: bench/tb_stroke_line_dda_3d.sv
// Self-checking testbench for the 3D stroke line generator with a built-in DDA predictor
`timescale 1ns / 1ps

module tb_stroke_line_dda_3d;
  import sldda_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int FRAC_SCALE   = 1 << FRAC_W;
  localparam int COORD_MIN    = -(1 << (COORD_W - 1));
  localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;

  // one emitted point as the block should present it
  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    last;
  } stroke_pt_t;

  logic                       clk;
  logic                       rst_n;
  logic                       push;
  logic                       full;
  logic signed [COORD_W-1:0]  in_point_x;
  logic signed [COORD_W-1:0]  in_point_y;
  logic signed [COORD_W-1:0]  in_point_z;
  logic                       in_stroke_start;
  logic                       empty;
  logic                       pop;
  logic signed [OUT_W-1:0]    out_x;
  logic signed [OUT_W-1:0]    out_y;
  logic signed [OUT_W-1:0]    out_z;
  logic                       out_last_point;

  // predictor state: the point the block keeps
  logic signed [COORD_W-1:0]  kept_x;
  logic signed [COORD_W-1:0]  kept_y;
  logic signed [COORD_W-1:0]  kept_z;
  logic                       have_kept;
  stroke_pt_t                 pending_pts[$];

  // stimulus side: last point offered and accepted
  int                         stim_x;
  int                         stim_y;
  int                         stim_z;

  int                         tx_gap_max;
  int                         rx_gap_max;
  int                         rx_hold_cycles;
  int                         mismatch_count;
  int                         points_checked;
  int                         cycle_count;

  stroke_line_dda_3d u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_stroke_start (in_stroke_start),
    .empty           (empty),
    .pop             (pop),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_last_point  (out_last_point)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycle_count,
               pending_pts.size());
      $display("stroke_line_dda_3d regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at point %0d: got %0d, want %0d", what, points_checked,
             got, want);
    mismatch_count++;
  endtask

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // fixed-point coordinate of step i on an axis, fraction truncated toward zero
  function automatic logic signed [OUT_W-1:0] dda_fixed(input int base, input int delta,
                                                       input int step, input int len);
    int v;
    v = base * FRAC_SCALE + (delta * step * FRAC_SCALE) / len;
    return v[OUT_W-1:0];
  endfunction

  // expected points for one accepted stroke point
  task automatic predict_stroke_point(input logic signed [COORD_W-1:0] nx,
                                      input logic signed [COORD_W-1:0] ny,
                                      input logic signed [COORD_W-1:0] nz,
                                      input logic new_stroke);
    int dx, dy, dz, ax, ay, az, len;
    stroke_pt_t pt;
    if (new_stroke || !have_kept) begin
      pt.x = dda_fixed(int'(nx), 0, 0, 1);
      pt.y = dda_fixed(int'(ny), 0, 0, 1);
      pt.z = dda_fixed(int'(nz), 0, 0, 1);
      pt.last = 1'b1;
      pending_pts = {pending_pts, pt};
    end else begin
      dx = int'(nx) - int'(kept_x);
      dy = int'(ny) - int'(kept_y);
      dz = int'(nz) - int'(kept_z);
      ax = abs_int(dx);
      ay = abs_int(dy);
      az = abs_int(dz);
      // major axis: z only when strictly largest, then y over x, ties to x
      if (az > ax && az > ay)
        len = az;
      else if (ay > ax)
        len = ay;
      else
        len = ax;
      // zero-length segment leaves everything as it was
      if (len == 0)
        return;
      for (int i = 1; i <= len; i++) begin
        pt.x = dda_fixed(int'(kept_x), dx, i, len);
        pt.y = dda_fixed(int'(kept_y), dy, i, len);
        pt.z = dda_fixed(int'(kept_z), dz, i, len);
        pt.last = (i == len);
        pending_pts = {pending_pts, pt};
      end
    end
    kept_x = nx;
    kept_y = ny;
    kept_z = nz;
    have_kept = 1'b1;
  endtask

  // one input transfer, entered and left at a falling edge
  task automatic send_point(input int x, input int y, input int z, input logic new_stroke);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    if (gap > 0) begin
      push = 1'b0;
      in_point_x = COORD_W'($urandom);
      in_point_y = COORD_W'($urandom);
      in_point_z = COORD_W'($urandom);
      in_stroke_start = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_point_x = COORD_W'(x);
    in_point_y = COORD_W'(y);
    in_point_z = COORD_W'(z);
    in_stroke_start = new_stroke;
    do @(posedge clk); while (full);
    predict_stroke_point(in_point_x, in_point_y, in_point_z, in_stroke_start);
    stim_x = int'(in_point_x);
    stim_y = int'(in_point_y);
    stim_z = int'(in_point_z);
    @(negedge clk);
  endtask

  function automatic int walk_coord(input int from, input int reach);
    int v;
    v = from + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // next point of the stroke within reach of the last one
  task automatic walk_point(input int reach);
    send_point(walk_coord(stim_x, reach), walk_coord(stim_y, reach),
               walk_coord(stim_z, reach), 1'b0);
  endtask

  // extremes, tie rules, stroke starts and zero-length segments
  task automatic test_directed();
    send_point(5, -7, 3, 1'b0);        // first point after reset, no stroke start
    send_point(5, -7, 3, 1'b0);        // zero length
    send_point(-32, -32, -32, 1'b1);
    send_point(31, 31, 31, 1'b0);      // longest segment, three-way tie to x
    send_point(31, 31, 31, 1'b1);      // stroke start on the kept point
    send_point(-32, 31, -32, 1'b0);    // x and z tie
    send_point(-32, -32, 31, 1'b0);    // y and z tie
    send_point(-31, -29, -32, 1'b0);   // z strictly largest
    send_point(0, -3, -5, 1'b0);
    send_point(-3, 0, -7, 1'b0);       // x and y tie, negative x and z deltas
    send_point(31, -32, 0, 1'b1);
    send_point(-32, 31, 0, 1'b0);      // opposite-sign tie
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 1, 1'b0);         // unit steps on each axis
    send_point(1, 0, 1, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(1, 1, 1, 1'b0);
    send_point(-32, -32, -32, 1'b1);
    send_point(-20, 31, -27, 1'b0);
    send_point(31, -32, 31, 1'b0);
  endtask

  // mostly well-formed strokes with random content, some noise
  task automatic test_random_strokes();
    int sel;
    int reach;
    for (int n = 0; n < 150; n++) begin
      sel = $urandom_range(0, 15);
      if (sel < 2) begin
        send_point(int'($signed(COORD_W'($urandom))), int'($signed(COORD_W'($urandom))),
                   int'($signed(COORD_W'($urandom))), 1'b1);
      end else if (sel == 2) begin
        send_point(int'($signed(COORD_W'($urandom))), int'($signed(COORD_W'($urandom))),
                   int'($signed(COORD_W'($urandom))), 1'($urandom));
      end else begin
        reach = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 6);
        walk_point(reach);
      end
    end
  endtask

  // receiver holds off for a long stretch while points keep arriving back to back
  task automatic test_back_pressure();
    tx_gap_max = 0;
    rx_hold_cycles = 600;
    send_point(stim_x, stim_y, stim_z, 1'b1);
    for (int n = 0; n < 21; n++)
      walk_point(5);
    tx_gap_max = 19;
  endtask

  // both sides at full rate
  task automatic test_no_idle();
    tx_gap_max = 0;
    rx_gap_max = 0;
    for (int n = 0; n < 40; n++)
      walk_point((n % 8 == 0) ? 40 : 3);
    tx_gap_max = 19;
    rx_gap_max = 19;
  endtask

  // result side: random idling and the long hold-off
  initial begin
    int idle;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      idle = rx_hold_cycles + ((rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0);
      rx_hold_cycles = 0;
      if (idle > 0) begin
        pop = 1'b0;
        repeat (idle) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // compare every result transfer with the oldest expected point
  always @(posedge clk) begin : check_points
    stroke_pt_t want;
    if (rst_n && pop && !empty) begin
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected point x", int'(out_x), 0);
      end else begin
        want = pending_pts.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", int'(out_x), int'(want.x));
        if (out_y !== want.y) report_mismatch("out_y", int'(out_y), int'(want.y));
        if (out_z !== want.z) report_mismatch("out_z", int'(out_z), int'(want.z));
        if (out_last_point !== want.last)
          report_mismatch("out_last_point", int'(out_last_point), int'(want.last));
      end
      points_checked++;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    in_stroke_start = 1'b0;
    kept_x = '0;
    kept_y = '0;
    kept_z = '0;
    have_kept = 1'b0;
    stim_x = 0;
    stim_y = 0;
    stim_z = 0;
    tx_gap_max = 19;
    rx_gap_max = 19;
    rx_hold_cycles = 0;
    mismatch_count = 0;
    points_checked = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_strokes();
    test_back_pressure();
    test_no_idle();
    push = 1'b0;

    // drain, then give the back end time to show any stray result
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("stroke_line_dda_3d regression: pass");
    else
      $display("stroke_line_dda_3d regression: fail");
    $finish;
  end

endmodule
